[rtl/ptt_pkg.sv]
// Shared types and constants for the periodic timer table.
package ptt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int OPCODE_W = 2;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int ID_W     = 16;
  localparam int NEXT_ID_W = ID_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REPLY,
    ST_CRD,
    ST_CCMP,
    ST_SRD,
    ST_SWR,
    ST_TRD,
    ST_TCMP,
    ST_TFLUSH
  } state_t;

  // one stored timer
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_fire;
  } entry_t;

  // one result word
  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   entry_id;
    logic [TAG_W-1:0]  fired_tag;
    logic              is_last;
  } rsp_t;

endpackage

[rtl/ptt_if.sv]
// Request and response channel interfaces for the periodic timer table.
interface ptt_req_if;
  logic                       valid;
  logic                       ready;
  logic [ptt_pkg::OPCODE_W-1:0] opcode;
  logic [ptt_pkg::TIME_W-1:0] now_ms;
  logic [ptt_pkg::TIME_W-1:0] interval_ms;
  logic [ptt_pkg::TAG_W-1:0]  event_tag;
  logic [ptt_pkg::ID_W-1:0]   target_id;

  modport source (output valid, opcode, now_ms, interval_ms, event_tag, target_id,
                  input ready);
  modport sink (input valid, opcode, now_ms, interval_ms, event_tag, target_id,
                output ready);
endinterface

interface ptt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ptt_pkg::ID_W-1:0]  entry_id;
  logic [ptt_pkg::TAG_W-1:0] fired_tag;
  logic                      is_last;

  modport source (output valid, kind, entry_id, fired_tag, is_last, input ready);
  modport sink (input valid, kind, entry_id, fired_tag, is_last, output ready);
endinterface

[rtl/periodic_event_timer_table_top.sv]
// Periodic timer table: sequencer around one entry memory, with an output word register.
// Register: reply word loaded in ST_REPLY once the output register is free. Cancel:
//   ST_CRD/ST_CCMP per entry searched, ST_SRD/ST_SWR per entry shifted, then a closing
//   state. Tick: ST_TRD/ST_TCMP per live entry, then end check and ST_TFLUSH, which loads
//   the last fired word. Throughput: one request at a time; a clear every cycle; a register
//   waits for its reply to load; cancel and tick hold off requests for their whole walk.
// Reset (rst, synchronous): table empty, next id 1, no word pending. Entry memory is not
//   cleared; only entries below the live count are ever read.
module periodic_event_timer_table_top #(
  parameter int MAX_ENTRIES = ptt_pkg::MAX_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst,
  ptt_req_if.sink  req,
  ptt_rsp_if.source rsp
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // ---------------------------------------------------------------
  // Entry memory: one write port, one registered read port.
  // Each entry holds id, tag, period and last fire time.
  // ---------------------------------------------------------------
  ptt_pkg::entry_t mem [MAX_ENTRIES];
  ptt_pkg::entry_t rd_data;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ptt_pkg::entry_t mem_wdata;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // Control and holding registers
  // ---------------------------------------------------------------
  ptt_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;          // live entries
  logic [ptt_pkg::NEXT_ID_W-1:0] next_id, next_id_next;
  logic [CNT_W-1:0] idx, idx_next;              // walk position (search, shift, tick)
  logic [ptt_pkg::RES_CNT_W-1:0] nfired, nfired_next;
  logic [ptt_pkg::TIME_W-1:0] now_q, now_q_next;
  logic [ptt_pkg::ID_W-1:0] target_q, target_q_next;
  logic [ptt_pkg::ID_W-1:0] reply_id, reply_id_next;

  // Fired entry held back until we know whether another one follows,
  // so is_last can be set on the final word of a tick.
  logic pend_valid, pend_valid_next;
  logic [ptt_pkg::ID_W-1:0]  pend_id, pend_id_next;
  logic [ptt_pkg::TAG_W-1:0] pend_tag, pend_tag_next;

  // Output word register
  logic          out_valid, out_valid_next;
  ptt_pkg::rsp_t out_word, out_word_next;

  logic req_ready;
  logic out_free;
  logic [CNT_W-1:0] idx_inc;
  logic [ptt_pkg::TIME_W-1:0] elapsed;
  logic due;
  logic reg_ok;

  assign out_free = !out_valid || rsp.ready;
  assign idx_inc  = idx + 1'b1;
  assign elapsed  = now_q - rd_data.last_fire;
  assign due      = (elapsed >= rd_data.period);
  assign reg_ok   = (req.interval_ms != '0) && (count < CNT_W'(MAX_ENTRIES))
                    && !next_id[ptt_pkg::NEXT_ID_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptt_pkg::ST_IDLE;
      count      <= '0;
      next_id    <= ptt_pkg::NEXT_ID_W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      nfired     <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      next_id    <= next_id_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      idx        <= idx_next;
      nfired     <= nfired_next;
    end
  end

  always_ff @(posedge clk) begin
    now_q    <= now_q_next;
    target_q <= target_q_next;
    reply_id <= reply_id_next;
    pend_id  <= pend_id_next;
    pend_tag <= pend_tag_next;
    out_word <= out_word_next;
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_next      = state;
    count_next      = count;
    next_id_next    = next_id;
    idx_next        = idx;
    nfired_next     = nfired;
    now_q_next      = now_q;
    target_q_next   = target_q;
    reply_id_next   = reply_id;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    pend_tag_next   = pend_tag;
    out_word_next   = out_word;
    out_valid_next  = out_valid && !rsp.ready;
    req_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx[IDX_W-1:0];
    mem_wdata       = rd_data;
    rd_en           = 1'b0;
    rd_addr         = idx[IDX_W-1:0];

    case (state)
      ptt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          now_q_next    = req.now_ms;
          target_q_next = req.target_id;
          idx_next      = '0;
          nfired_next   = '0;
          case (ptt_pkg::op_t'(req.opcode))
            ptt_pkg::OP_REGISTER: begin
              // append at the end of the table
              reply_id_next = '0;
              if (reg_ok) begin
                mem_we              = 1'b1;
                mem_waddr           = count[IDX_W-1:0];
                mem_wdata.id        = next_id[ptt_pkg::ID_W-1:0];
                mem_wdata.tag       = req.event_tag;
                mem_wdata.period    = req.interval_ms;
                mem_wdata.last_fire = req.now_ms;
                count_next          = count + 1'b1;
                next_id_next        = next_id + 1'b1;
                reply_id_next       = next_id[ptt_pkg::ID_W-1:0];
              end
              state_next = ptt_pkg::ST_REPLY;
            end
            ptt_pkg::OP_CANCEL: state_next = ptt_pkg::ST_CRD;
            ptt_pkg::OP_TICK:   state_next = ptt_pkg::ST_TRD;
            ptt_pkg::OP_CLEAR: begin
              count_next   = '0;
              next_id_next = ptt_pkg::NEXT_ID_W'(1);
            end
            default: state_next = ptt_pkg::ST_IDLE;
          endcase
        end
      end

      ptt_pkg::ST_REPLY: begin
        if (out_free) begin
          out_valid_next          = 1'b1;
          out_word_next.kind      = 1'b0;
          out_word_next.entry_id  = reply_id;
          out_word_next.fired_tag = '0;
          out_word_next.is_last   = 1'b1;
          state_next              = ptt_pkg::ST_IDLE;
        end
      end

      // cancel: search for the target id
      ptt_pkg::ST_CRD: begin
        if (idx >= count) begin
          state_next = ptt_pkg::ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = ptt_pkg::ST_CCMP;
        end
      end

      ptt_pkg::ST_CCMP: begin
        if (rd_data.id == target_q) begin
          state_next = ptt_pkg::ST_SRD;
        end else begin
          idx_next   = idx_inc;
          state_next = ptt_pkg::ST_CRD;
        end
      end

      // cancel: shift later entries down by one
      ptt_pkg::ST_SRD: begin
        if (idx_inc >= count) begin
          count_next = count - 1'b1;
          state_next = ptt_pkg::ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx_inc[IDX_W-1:0];
          state_next = ptt_pkg::ST_SWR;
        end
      end

      ptt_pkg::ST_SWR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[IDX_W-1:0];
        mem_wdata  = rd_data;
        idx_next   = idx_inc;
        state_next = ptt_pkg::ST_SRD;
      end

      // tick: walk the table in order
      ptt_pkg::ST_TRD: begin
        if ((idx >= count) || (nfired == ptt_pkg::RES_CNT_W'(ptt_pkg::MAX_RESULTS))) begin
          state_next = ptt_pkg::ST_TFLUSH;
        end else begin
          rd_en      = 1'b1;
          state_next = ptt_pkg::ST_TCMP;
        end
      end

      ptt_pkg::ST_TCMP: begin
        if (!due) begin
          idx_next   = idx_inc;
          state_next = ptt_pkg::ST_TRD;
        end else if (!pend_valid || out_free) begin
          mem_we              = 1'b1;
          mem_waddr           = idx[IDX_W-1:0];
          mem_wdata           = rd_data;
          mem_wdata.last_fire = now_q;
          if (pend_valid) begin
            out_valid_next          = 1'b1;
            out_word_next.kind      = 1'b1;
            out_word_next.entry_id  = pend_id;
            out_word_next.fired_tag = pend_tag;
            out_word_next.is_last   = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_id_next    = rd_data.id;
          pend_tag_next   = rd_data.tag;
          nfired_next     = nfired + 1'b1;
          idx_next        = idx_inc;
          state_next      = ptt_pkg::ST_TRD;
        end
      end

      ptt_pkg::ST_TFLUSH: begin
        if (!pend_valid) begin
          state_next = ptt_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_next          = 1'b1;
          out_word_next.kind      = 1'b1;
          out_word_next.entry_id  = pend_id;
          out_word_next.fired_tag = pend_tag;
          out_word_next.is_last   = 1'b1;
          pend_valid_next         = 1'b0;
          state_next              = ptt_pkg::ST_IDLE;
        end
      end

      default: state_next = ptt_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------
  assign req.ready     = req_ready;
  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_word.kind;
  assign rsp.entry_id  = out_word.entry_id;
  assign rsp.fired_tag = out_word.fired_tag;
  assign rsp.is_last   = out_word.is_last;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("live entry count beyond table size");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    nfired <= ptt_pkg::RES_CNT_W'(ptt_pkg::MAX_RESULTS))
    else $error("too many fired words for one tick");

  a_reply_form: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.kind) |-> (rsp.is_last && (rsp.fired_tag == '0)))
    else $error("register reply not a single final word");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ptt_pkg::ST_IDLE) |-> !pend_valid)
    else $error("fired word left behind after tick");

endmodule

[tb/sv/periodic_event_timer_table_top_tb.sv]
// Self-checking bench for the periodic timer table: predicts register replies and fired events.
module periodic_event_timer_table_top_tb;

  localparam int TABLE_DEPTH    = ptt_pkg::MAX_ENTRIES_DEF;
  localparam int ID_MAX         = (1 << ptt_pkg::ID_W) - 1;
  // No word moves on either side for this many cycles: the block is stuck.
  // Longest legal quiet stretch is the receiver hold-off below plus one tick walk.
  localparam int WATCHDOG_LIMIT = 20000;
  // Cancel over a full table walks every entry; leave room after the last word.
  localparam int TAIL_CYCLES    = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 60;

  // Expected-word tracker: keeps its own copy of the timer table and queues the
  // words each accepted request should produce, in order.
  class timer_scoreboard;
    logic [ptt_pkg::ID_W-1:0]      slot_ids    [TABLE_DEPTH];
    logic [ptt_pkg::TAG_W-1:0]     slot_tags   [TABLE_DEPTH];
    logic [ptt_pkg::TIME_W-1:0]    slot_period [TABLE_DEPTH];
    logic [ptt_pkg::TIME_W-1:0]    slot_last   [TABLE_DEPTH];
    int unsigned                   live_count;
    logic [ptt_pkg::NEXT_ID_W-1:0] next_id;
    ptt_pkg::rsp_t                 pending_words[$];
    int unsigned                   mismatches;

    function new();
      live_count = 0;
      next_id    = 1;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    // append one expected word at the tail
    function void queue_word(ptt_pkg::rsp_t word);
      pending_words = {pending_words, word};
    endfunction

    // a live id when there is one, else anything
    function logic [ptt_pkg::ID_W-1:0] pick_live_id();
      if (live_count == 0) return ptt_pkg::ID_W'($urandom);
      return slot_ids[$urandom_range(0, live_count - 1)];
    endfunction

    function void note_request(ptt_pkg::op_t op, logic [ptt_pkg::TIME_W-1:0] now,
                               logic [ptt_pkg::TIME_W-1:0] interval,
                               logic [ptt_pkg::TAG_W-1:0] tag,
                               logic [ptt_pkg::ID_W-1:0] target);
      ptt_pkg::rsp_t word;
      ptt_pkg::rsp_t held;
      bit            have_held;
      int unsigned   fired;
      have_held = 1'b0;
      fired     = 0;
      case (op)
        ptt_pkg::OP_REGISTER: begin
          word = '{kind: 1'b0, entry_id: '0, fired_tag: '0, is_last: 1'b1};
          if (interval != 0 && live_count < TABLE_DEPTH && next_id <= ID_MAX) begin
            word.entry_id           = next_id[ptt_pkg::ID_W-1:0];
            slot_ids[live_count]    = next_id[ptt_pkg::ID_W-1:0];
            slot_tags[live_count]   = tag;
            slot_period[live_count] = interval;
            slot_last[live_count]   = now;
            live_count++;
            next_id++;
          end
          queue_word(word);
        end
        ptt_pkg::OP_CANCEL: begin
          for (int unsigned k = 0; k < live_count; k++) begin
            if (slot_ids[k] == target) begin
              for (int unsigned j = k; j + 1 < live_count; j++) begin
                slot_ids[j]    = slot_ids[j+1];
                slot_tags[j]   = slot_tags[j+1];
                slot_period[j] = slot_period[j+1];
                slot_last[j]   = slot_last[j+1];
              end
              live_count--;
              break;
            end
          end
        end
        ptt_pkg::OP_TICK: begin
          // hold one word back so the final one can be marked last
          for (int unsigned k = 0; k < live_count && fired < ptt_pkg::MAX_RESULTS; k++) begin
            if (ptt_pkg::TIME_W'(now - slot_last[k]) >= slot_period[k]) begin
              slot_last[k] = now;
              if (have_held) queue_word(held);
              held = '{kind: 1'b1, entry_id: slot_ids[k], fired_tag: slot_tags[k],
                       is_last: 1'b0};
              have_held = 1'b1;
              fired++;
            end
          end
          if (have_held) begin
            held.is_last = 1'b1;
            queue_word(held);
          end
        end
        ptt_pkg::OP_CLEAR: begin
          live_count = 0;
          next_id    = 1;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [ptt_pkg::ID_W-1:0] got,
                         logic [ptt_pkg::ID_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_word(ptt_pkg::rsp_t got);
      ptt_pkg::rsp_t want;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, entry_id", got.entry_id, '0);
        return;
      end
      want = pending_words.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.entry_id !== want.entry_id) report_mismatch("entry_id", got.entry_id, want.entry_id);
      if (got.fired_tag !== want.fired_tag)
        report_mismatch("fired_tag", got.fired_tag, want.fired_tag);
      if (got.is_last !== want.is_last) report_mismatch("is_last", got.is_last, want.is_last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptt_req_if req_ch ();
  ptt_rsp_if rsp_ch ();

  periodic_event_timer_table_top #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  timer_scoreboard sb;

  // Idle percentages per phase; recv side is read by the receiver process at the edge,
  // so it is only ever updated with nonblocking writes.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // set while the receiver is held off for the back-pressure stretch
  logic hold_rsp = 1'b0;
  // running millisecond clock that the random part feeds to register and tick
  logic [ptt_pkg::TIME_W-1:0] clock_ms;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  // Receiver: ready drops at random, or for a whole stretch while hold_rsp is set.
  always @(posedge clk) begin
    rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every accepted response word goes against the oldest expectation.
  always @(posedge clk) begin
    ptt_pkg::rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{kind: rsp_ch.kind, entry_id: rsp_ch.entry_id, fired_tag: rsp_ch.fired_tag,
              is_last: rsp_ch.is_last};
      sb.check_word(got);
    end
  end

  // Watchdog: counts edges with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
          $display("** periodic_event_timer_table_top: FAILED **");
          $finish;
        end
      end
    end
  end

  // Offers one request word, with random idle cycles ahead of it, and waits for the
  // accept. valid stays high from one word to the next when no gap is drawn.
  task automatic send_word(ptt_pkg::op_t op, logic [ptt_pkg::TIME_W-1:0] now,
                           logic [ptt_pkg::TIME_W-1:0] interval,
                           logic [ptt_pkg::TAG_W-1:0] tag,
                           logic [ptt_pkg::ID_W-1:0] target);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.now_ms      <= now;
    req_ch.interval_ms <= interval;
    req_ch.event_tag   <= tag;
    req_ch.target_id   <= target;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    sb.note_request(op, now, interval, tag, target);
  endtask

  task automatic hold_receiver(int cycles);
    hold_rsp <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rsp <= 1'b0;
  endtask

  // Field extremes, every opcode, wraparound of the elapsed time, refusals,
  // a full table that fires all sixteen entries at once, and a mid-table cancel.
  task automatic run_directed();
    send_word(ptt_pkg::OP_REGISTER, '0, '0, 16'h1234, '0);      // zero interval: refused
    send_word(ptt_pkg::OP_REGISTER, '0, '1, '1, '0);            // id 1, longest period
    send_word(ptt_pkg::OP_REGISTER, '1, 32'd1, '0, '0);         // id 2, set just before wrap
    send_word(ptt_pkg::OP_TICK, '0, '0, '0, '0);                // elapsed wraps to 1: id 2 fires
    send_word(ptt_pkg::OP_TICK, '1, '0, '0, '0);                // both due
    send_word(ptt_pkg::OP_TICK, '1, '0, '0, '0);                // nothing due
    send_word(ptt_pkg::OP_CANCEL, '0, '0, '0, '0);              // id 0 never matches
    send_word(ptt_pkg::OP_CANCEL, '0, '0, '0, 16'd1);           // drop the head, shift down
    for (int k = 0; k < TABLE_DEPTH - 1; k++)
      send_word(ptt_pkg::OP_REGISTER, 32'd100, 32'd5, ptt_pkg::TAG_W'(16'hA000 + k), '0);
    send_word(ptt_pkg::OP_REGISTER, 32'd100, 32'd5, 16'hBEEF, '0); // table full: refused
    send_word(ptt_pkg::OP_TICK, 32'd200, '0, '0, '0);           // all sixteen fire
    send_word(ptt_pkg::OP_CANCEL, '0, '0, '0, 16'd10);          // cancel from the middle
    send_word(ptt_pkg::OP_TICK, 32'd203, '0, '0, '0);           // only the 1 ms entry is due
    send_word(ptt_pkg::OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Mostly meaningful traffic: short periods against a slowly advancing clock so
  // ticks keep firing, cancels aimed at live ids, and the table filling up.
  // Unused fields carry random noise the block has to ignore.
  task automatic run_random(int count);
    int unsigned                pick;
    int unsigned                shape;
    ptt_pkg::op_t               op;
    logic [ptt_pkg::TIME_W-1:0] interval;
    logic [ptt_pkg::TAG_W-1:0]  tag;
    logic [ptt_pkg::ID_W-1:0]   target;
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      shape    = $urandom_range(0, 19);
      interval = $urandom;
      tag      = ptt_pkg::TAG_W'($urandom);
      target   = ptt_pkg::ID_W'($urandom);
      if (pick < 4) begin
        op = ptt_pkg::OP_CLEAR;
      end else if (pick < 40) begin
        op = ptt_pkg::OP_REGISTER;
        if (shape == 0) interval = '0;
        else if (shape != 1) interval = $urandom_range(1, 60);
        clock_ms += $urandom_range(0, 3);
      end else if (pick < 60) begin
        op = ptt_pkg::OP_CANCEL;
        if (shape > 3) target = sb.pick_live_id();
      end else begin
        op = ptt_pkg::OP_TICK;
        if (shape == 0) clock_ms = $urandom;   // big jump: most entries due
        else clock_ms += $urandom_range(0, 40);
      end
      send_word(op, clock_ms, interval, tag, target);
    end
  endtask

  initial begin
    sb = new();
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= ptt_pkg::OP_REGISTER;
    req_ch.now_ms      <= '0;
    req_ch.interval_ms <= '0;
    req_ch.event_tag   <= '0;
    req_ch.target_id   <= '0;
    clock_ms = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender idles now and then, receiver mostly stalls
    send_idle_pct = 15;
    recv_idle_pct <= 86;
    run_directed();
    run_random(PHASE_ITEMS);

    // roles swapped; start the clock just short of the wrap
    send_idle_pct = 86;
    recv_idle_pct <= 15;
    clock_ms = 32'hFFFF_FF80;
    run_random(PHASE_ITEMS);

    // no idling, but the receiver blocks for a long stretch first so the block
    // backs up and stalls its request side while words keep being offered
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    fork
      hold_receiver(HOLD_CYCLES);
    join_none
    run_random(PHASE_ITEMS);
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** periodic_event_timer_table_top: PASSED **");
    end else begin
      $display("** periodic_event_timer_table_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/periodic_event_timer_table_top.sv
tb/sv/periodic_event_timer_table_top_tb.sv
